// ===== design/dmmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dmmt_pkg
// Shared widths, controller state and the command / status bundles of the
// decimating min / max / mean trend recorder.
// ----------------------------------------------------------------------------
package dmmt_pkg;

   localparam int DATA_W  = 32;              // sample and result field width
   localparam int CNT_W   = 7;               // block size register and counter
   localparam int SUM_W   = DATA_W + CNT_W;  // block sum, never overflows
   localparam int SLOT_W  = 7;               // slot_index field width
   localparam int RSP_W   = 264;             // eight 32-bit fields, slot, pad
   localparam int RING_W  = 3 * DATA_W;      // {mean, high, low}

   localparam int DEF_TREND_POINTS = 128;
   localparam int DEF_MAX_BLOCK    = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_WRITE,
      ST_SCAN,
      ST_DRAIN,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic ready;     // input channel may take an item
      logic take;      // item accepted this cycle
      logic div_load;  // latch divisor and magnitude, clear block count
      logic div_step;  // one quotient bit
      logic ring_wr;   // store point, advance pointer
      logic scan_rd;   // read one ring slot
      logic out_load;  // move result into output register
   } cmd_type;

   typedef struct packed {
      logic complete;  // the item now offered completes a block
      logic div_done;  // last quotient bit this cycle
      logic scan_last; // last valid slot read this cycle
      logic out_free;  // output register can take a result
   } status_type;

endpackage

// ===== design/decimating_min_max_mean_trend.sv =====
// ----------------------------------------------------------------------------
// decimating_min_max_mean_trend
// Gathers blocks of samples, stores block mean / min / max in a trend ring
// and reports the point together with the trend-wide extremes.
// ----------------------------------------------------------------------------
// a sample that does not close a block is taken in one cycle, back to back
// a closing sample holds the input while the block is finished: setup,
// SUM_W = 39 serial divide steps, ring write, one read per filled ring slot
// (1 .. TREND_POINTS slots), drain and load, longer while the output
// register is full; reset clears counters, pointer, fill count and block
// size (1); ring data stays, fill count marks points
module decimating_min_max_mean_trend
   import dmmt_pkg::*;
#(
   parameter int TREND_POINTS = DEF_TREND_POINTS,
   parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
   input  logic              clock,
   input  logic              reset,
   // sample[31:0]
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   // point_mean, point_min, point_max, trend_min, trend_max, trend_mean_min,
   // trend_mean_max, trend_span (32 bits each), slot_index[262:256], zero pad
   output logic [RSP_W-1:0]  rsp_tdata,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [CNT_W-1:0]  csr_data,
   input  logic              csr_valid,
   output logic              csr_ready
);

   cmd_type    cmd;
   status_type stat;

   assign req_tready = cmd.ready;
   assign csr_ready  = 1'b1;

   dmmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (stat),
      .cmd        (cmd)
   );

   dmmt_datapath #(
      .TREND_POINTS (TREND_POINTS),
      .MAX_BLOCK    (MAX_BLOCK)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // a result is only moved into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded over a pending item");

   // the slot just written is always read back in the scan
   a_scan_after_write: assert property (@(posedge clock) disable iff (reset)
      cmd.ring_wr |=> cmd.scan_rd)
      else $error("ring scan did not follow point write");

   // divider finishes straight into the ring write
   a_div_to_write: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && stat.div_done) |=> cmd.ring_wr)
      else $error("ring write missing after divide");

   // no ring read while a point is being stored
   a_ring_ports: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ring_wr && cmd.scan_rd))
      else $error("ring read and write in one cycle");

endmodule

// ===== design/dmmt_ram.sv =====
// ----------------------------------------------------------------------------
// dmmt_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dmmt_datapath.sv =====
// ----------------------------------------------------------------------------
// dmmt_datapath
// Block accumulator, serial divider, trend ring with fill count, ring scan
// and output register.
// ----------------------------------------------------------------------------
module dmmt_datapath
   import dmmt_pkg::*;
#(
   parameter int TREND_POINTS = DEF_TREND_POINTS,
   parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        stat,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              csr_valid,
   input  logic [CNT_W-1:0]  csr_data,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [RSP_W-1:0]  rsp_tdata
);

   localparam int PTR_W  = $clog2(TREND_POINTS);
   localparam int FILL_W = $clog2(TREND_POINTS + 1);
   localparam int DIVC_W = $clog2(SUM_W + 1);
   localparam int SPP_CAP = (MAX_BLOCK > (2 ** CNT_W - 1)) ? (2 ** CNT_W - 1) : MAX_BLOCK;
   localparam logic [CNT_W-1:0]  MAX_SPP   = CNT_W'(SPP_CAP);
   localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(TREND_POINTS - 1);
   localparam logic [FILL_W-1:0] FULL      = FILL_W'(TREND_POINTS);
   localparam logic [DIVC_W-1:0] DIV_LAST  = DIVC_W'(SUM_W - 1);

   // configuration
   logic [CNT_W-1:0] spp_ff, spp_in;

   always_comb begin
      spp_in = spp_ff;
      if (csr_valid) begin
         priority if (csr_data == '0) begin
            spp_in = CNT_W'(1);
         end else if (csr_data > MAX_SPP) begin
            spp_in = MAX_SPP;
         end else begin
            spp_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spp_ff <= CNT_W'(1);
      end else begin
         spp_ff <= spp_in;
      end
   end

   // block accumulator
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [DATA_W-1:0] low_ff, low_in, high_ff, high_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [DATA_W-1:0] sample;
   logic [CNT_W:0]           count_inc;

   assign sample    = signed'(req_tdata);
   assign count_inc = {1'b0, count_ff} + (CNT_W + 1)'(1);
   assign stat.complete = count_inc >= {1'b0, spp_ff};

   always_comb begin
      sum_in   = sum_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      count_in = count_ff;
      if (cmd.take) begin
         count_in = count_inc[CNT_W-1:0];
         if (count_ff == '0) begin
            sum_in  = SUM_W'(sample);
            low_in  = sample;
            high_in = sample;
         end else begin
            sum_in = sum_ff + SUM_W'(sample);
            if (sample < low_ff) begin
               low_in = sample;
            end
            if (sample > high_ff) begin
               high_in = sample;
            end
         end
      end else if (cmd.div_load) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      sum_ff  <= sum_in;
      low_ff  <= low_in;
      high_ff <= high_in;
   end

   // restoring divider on magnitudes, one quotient bit a cycle
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in, dvs_ff;
   logic              neg_ff;
   logic [DIVC_W-1:0] divc_ff, divc_in;
   logic [CNT_W:0]    trial, diff;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign stat.div_done = (divc_ff == DIV_LAST);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      divc_in = divc_ff;
      if (cmd.div_load) begin
         quo_in  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
         rem_in  = '0;
         divc_in = '0;
      end else if (cmd.div_step) begin
         divc_in = divc_ff + DIVC_W'(1);
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divc_ff <= '0;
      end else begin
         divc_ff <= divc_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (cmd.div_load) begin
         dvs_ff <= count_ff;
         neg_ff <= sum_ff[SUM_W-1];
      end
   end

   // trend ring, valid slots are 0 .. fill-1 since writes start at slot 0
   logic [PTR_W-1:0]         wp_ff, slot_ff, scan_ff;
   logic [FILL_W-1:0]        fill_ff;
   logic signed [DATA_W-1:0] mean, mean_ff;
   logic [SUM_W-1:0]         quo_signed;
   logic [RING_W-1:0]        rd_data;

   assign quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;
   assign mean       = signed'(quo_signed[DATA_W-1:0]);
   assign stat.scan_last = ({1'b0, scan_ff} == (fill_ff - FILL_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
         scan_ff <= '0;
      end else begin
         if (cmd.ring_wr) begin
            wp_ff   <= (wp_ff == LAST_SLOT) ? '0 : wp_ff + PTR_W'(1);
            scan_ff <= '0;
            if (fill_ff != FULL) begin
               fill_ff <= fill_ff + FILL_W'(1);
            end
         end else if (cmd.scan_rd) begin
            scan_ff <= scan_ff + PTR_W'(1);
         end
      end
      if (cmd.ring_wr) begin
         slot_ff <= wp_ff;
         mean_ff <= mean;
      end
   end

   dmmt_ram #(
      .WIDTH (RING_W),
      .DEPTH (TREND_POINTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.ring_wr),
      .wr_addr (wp_ff),
      .wr_data ({mean, high_ff, low_ff}),
      .rd_en   (cmd.scan_rd),
      .rd_addr (scan_ff),
      .rd_data (rd_data)
   );

   // scan fold, read data arrives in the cycle after the address
   logic                     pend_ff, first_ff;
   logic signed [DATA_W-1:0] r_low, r_high, r_mean;
   logic signed [DATA_W-1:0] tmin_ff, tmax_ff, mmin_ff, mmax_ff;

   assign r_low  = signed'(rd_data[DATA_W-1:0]);
   assign r_high = signed'(rd_data[2*DATA_W-1:DATA_W]);
   assign r_mean = signed'(rd_data[3*DATA_W-1:2*DATA_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         pend_ff <= cmd.scan_rd;
         if (cmd.ring_wr) begin
            first_ff <= 1'b1;
         end else if (pend_ff) begin
            first_ff <= 1'b0;
         end
      end
      if (pend_ff) begin
         if (first_ff || r_low < tmin_ff) begin
            tmin_ff <= r_low;
         end
         if (first_ff || r_high > tmax_ff) begin
            tmax_ff <= r_high;
         end
         if (first_ff || r_mean < mmin_ff) begin
            mmin_ff <= r_mean;
         end
         if (first_ff || r_mean > mmax_ff) begin
            mmax_ff <= r_mean;
         end
      end
   end

   // output register
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [DATA_W-1:0] span;

   assign span = DATA_W'(tmax_ff) - DATA_W'(tmin_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= {(RSP_W - 8 * DATA_W - SLOT_W)'(0), SLOT_W'(slot_ff), span,
                         mmax_ff, mmin_ff, tmax_ff, tmin_ff, high_ff, low_ff, mean_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/dmmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmmt_ctrl
// Sequencer: accumulate, divide, store point, rescan ring, hand off result.
// ----------------------------------------------------------------------------
module dmmt_ctrl
   import dmmt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  status_type stat,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && stat.complete) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:  state_in = ST_DIV;
         ST_DIV: begin
            if (stat.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_LOAD;
         ST_LOAD: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            cmd.take  = req_tvalid;
         end
         ST_PREP:  cmd.div_load = 1'b1;
         ST_DIV:   cmd.div_step = 1'b1;
         ST_WRITE: cmd.ring_wr  = 1'b1;
         ST_SCAN:  cmd.scan_rd  = 1'b1;
         ST_DRAIN: cmd = '0;
         ST_LOAD:  cmd.out_load = stat.out_free;
         default:  cmd = '0;
      endcase
   end

endmodule
